// ===== rtl/lrt_pkg.sv =====
// Package for the linear ramp tween block: field widths, payload types and
// the ramp length limit. No dependencies; compile first.
package lrt_pkg;

    localparam int TIME_W  = 32;               // millisecond time stamps
    localparam int VAL_W   = 32;               // signed Q16.16 values
    localparam int DUR_W   = 16;               // ramp length, also span and elapsed
    localparam int MAG_W   = VAL_W + 1;        // |end - start| needs one more bit
    localparam int PROD_W  = MAG_W + DUR_W;    // magnitude times elapsed

    localparam int MUL_CNT_W = $clog2(DUR_W);
    localparam int DIV_CNT_W = $clog2(VAL_W);

    localparam logic [DUR_W-1:0] MAX_RAMP_MS = DUR_W'(60 * 1000);

    typedef logic [TIME_W-1:0]       time_ms_t;
    typedef logic signed [VAL_W-1:0] q16_t;
    typedef logic [DUR_W-1:0]        dur_t;
    typedef logic [MAG_W-1:0]        mag_t;
    typedef logic [PROD_W-1:0]       prod_t;

endpackage

// ===== rtl/lrt_if.sv =====
// Valid/ready channel interfaces for the ramp tween: input sample and result.
// Depends on lrt_pkg.
interface lrt_in_if import lrt_pkg::*;;
    logic     valid;
    logic     ready;
    time_ms_t now_ms;
    q16_t     target_value;

    modport source (output valid, output now_ms, output target_value, input ready);
    modport sink   (input valid, input now_ms, input target_value, output ready);
endinterface

interface lrt_out_if import lrt_pkg::*;;
    logic valid;
    logic ready;
    q16_t output_value;

    modport source (output valid, output output_value, input ready);
    modport sink   (input valid, input output_value, output ready);
endinterface

// ===== rtl/lrt_mul.sv =====
// Bit-serial shift-add multiplier: 33-bit magnitude times 16-bit elapsed time,
// one multiplier bit per cycle. Depends on lrt_pkg.
module lrt_mul import lrt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  mag_t  mcand,
    input  dur_t  mplr,
    output logic  done,
    output prod_t product
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    mag_t                 mcand_reg;
    mag_t                 hi_reg;
    dur_t                 lo_reg;
    logic [MAG_W:0]       sum;

    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= MUL_CNT_W'(DUR_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // partial sum shifts right together with the consumed multiplier bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= mcand;
            hi_reg    <= '0;
            lo_reg    <= mplr;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[MAG_W:1];
            lo_reg <= {sum[0], lo_reg[DUR_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

// ===== rtl/lrt_div.sv =====
// Bit-serial restoring divider: product over ramp span, one quotient bit per
// cycle. Depends on lrt_pkg.
module lrt_div import lrt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  prod_t            dividend,
    input  dur_t             divisor,
    output logic             done,
    output logic [VAL_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    dur_t                 div_reg;
    dur_t                 rem_reg;
    logic [VAL_W-1:0]     quo_reg;
    logic [DUR_W:0]       trial;
    logic                 fits;

    // remainder stays below the divisor, so 16 bits hold it
    assign trial = {rem_reg, quo_reg[VAL_W-1]} - {1'b0, div_reg};
    assign fits  = !trial[DUR_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(VAL_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // quotient is known to fit 32 bits, so the top bits seed the remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            rem_reg <= dividend[VAL_W+DUR_W-1:VAL_W];
            quo_reg <= dividend[VAL_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[DUR_W-1:0] : {rem_reg[DUR_W-2:0], quo_reg[VAL_W-1]};
            quo_reg <= {quo_reg[VAL_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/linear_ramp_tween_top.sv =====
// Linear ramp tween top level: ramp state, sequencer and output register.
// Depends on lrt_pkg, lrt_if, lrt_mul, lrt_div.
//
//  channel  dir  payload                         handshake
//  sample   in   now_ms[31:0], target_value[31:0] valid/ready
//  result   out  output_value[31:0]               valid/ready
//  cfg      in   cfg_wr_data[15:0]                cfg_wr_en
//
// Inside a ramp window a beat passes the window test, the bit-serial
// multiplier, a handoff to the bit-serial divider, a handoff back to the
// sequencer, the output load and the next accept.
// Outside the window a beat skips both units: window test, output load, accept.
// Reset clears the ramp state and the duration register to zero.
// A finished result waits in the output register; a new beat is taken
// meanwhile, and the sequencer holds only if a second result is ready first.
module linear_ramp_tween_top import lrt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  dur_t       cfg_wr_data,
    lrt_in_if.sink     sample,
    lrt_out_if.source  result
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg;
    dur_t       dur_reg;
    q16_t       last_target_reg;
    q16_t       start_value_reg;
    q16_t       end_value_reg;
    q16_t       present_reg;
    time_ms_t   start_time_reg;
    time_ms_t   end_time_reg;
    time_ms_t   now_reg;
    logic       neg_reg;
    q16_t       res_reg;
    logic       out_valid_reg;
    q16_t       out_data_reg;

    logic             accept;
    logic             new_ramp;
    dur_t             dur_clamped;
    logic             in_win;
    dur_t             span;
    dur_t             elapsed;
    logic [MAG_W-1:0] diff;
    mag_t             mag;
    logic             mul_start;
    logic             mul_done;
    prod_t            product;
    logic             div_done;
    logic [VAL_W-1:0] quotient;
    logic             out_free;

    assign accept      = sample.valid && sample.ready;
    assign new_ramp    = sample.target_value != last_target_reg;
    assign dur_clamped = (dur_reg > MAX_RAMP_MS) ? MAX_RAMP_MS : dur_reg;

    // inside the window end > start, so span and elapsed fit 16 bits
    assign in_win  = (start_time_reg <= now_reg) && (now_reg < end_time_reg);
    assign span    = DUR_W'(end_time_reg - start_time_reg);
    assign elapsed = DUR_W'(now_reg - start_time_reg);
    assign diff    = {end_value_reg[VAL_W-1], end_value_reg}
                   - {start_value_reg[VAL_W-1], start_value_reg};
    assign mag     = diff[MAG_W-1] ? (~diff + 1'b1) : diff;

    assign mul_start = (state_reg == S_EVAL) && in_win;
    assign out_free  = !out_valid_reg || result.ready;

    lrt_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mag),
        .mplr    (elapsed),
        .done    (mul_done),
        .product (product)
    );

    lrt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mul_done),
        .dividend (product),
        .divisor  (span),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            dur_reg         <= '0;
            last_target_reg <= '0;
            start_value_reg <= '0;
            end_value_reg   <= '0;
            present_reg     <= '0;
            start_time_reg  <= '0;
            end_time_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                dur_reg <= cfg_wr_data;
            end
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (new_ramp)
                        begin
                            last_target_reg <= sample.target_value;
                            start_value_reg <= present_reg;
                            end_value_reg   <= sample.target_value;
                            start_time_reg  <= sample.now_ms;
                            end_time_reg    <= sample.now_ms + TIME_W'(dur_clamped);
                        end
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    state_reg <= in_win ? S_MUL : S_DONE;
                end
                S_MUL:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        present_reg <= res_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg <= sample.now_ms;
        end
        if (state_reg == S_EVAL)
        begin
            neg_reg <= diff[MAG_W-1];
            res_reg <= end_value_reg;
        end
        if (div_done)
        begin
            // wraps modulo 2^32 like the 32-bit result field
            res_reg <= neg_reg ? (start_value_reg - q16_t'(quotient))
                               : (start_value_reg + q16_t'(quotient));
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign sample.ready        = (state_reg == S_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.output_value = out_data_reg;

endmodule

// ===== rtl/lrt_checker.sv =====
// Port-level checks for the linear ramp tween top, attached by bind.
// Depends on lrt_pkg and linear_ramp_tween_top.
module lrt_checker import lrt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input q16_t out_value
);

    // one beat in flight: no second accept right after one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken on the cycle after an accept");

    // a result needs at least the window test before it shows
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
        else $error("result rose one cycle after accept");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_value)))
        else $error("stalled result beat changed");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind linear_ramp_tween_top lrt_checker u_lrt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_value (result.output_value)
);
